// ===== sv/nns_pkg.sv =====
// Shared constants and types for the nearest-neighbor search block.
`default_nettype none

package nns_pkg;

	// Parameter defaults
	localparam int MAX_ROWS_DEF = 1024;
	localparam int MAX_DIMS_DEF = 8;
	localparam int COMP_W_DEF   = 16;

	// Fixed field widths
	localparam int ROW_IN_W   = 10;
	localparam int DIM_IN_W   = 3;
	localparam int DIST_W     = 35;
	localparam int ROWS_CFG_W = 11;
	localparam int DIMS_CFG_W = 4;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS = 2'd1;

	// Register reset values
	localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 11'd1024;
	localparam logic [DIMS_CFG_W-1:0] DIMS_RST = 4'd5;

	// Request types
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Largest distance, saturation value
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Tag that travels with each row through the distance pipeline
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tag_t;

endpackage

`default_nettype wire

// ===== sv/nns_table.sv =====
// Feature table: one synchronous memory lane per vector component.
`default_nettype none

module nns_table #(
	parameter int MAX_ROWS = nns_pkg::MAX_ROWS_DEF,
	parameter int MAX_DIMS = nns_pkg::MAX_DIMS_DEF,
	parameter int COMPONENT_WIDTH = nns_pkg::COMP_W_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      wr_en,
	input  wire logic [$clog2(MAX_ROWS)-1:0]               wr_row,
	input  wire logic [nns_pkg::DIM_IN_W-1:0]              wr_dim,
	input  wire logic [COMPONENT_WIDTH-1:0]                wr_data,
	input  wire logic                                      rd_en,
	input  wire logic [$clog2(MAX_ROWS)-1:0]               rd_row,
	output logic      [MAX_DIMS-1:0][COMPONENT_WIDTH-1:0]  rd_data
);
	import nns_pkg::*;

	// One lane per component; all lanes read the same row together
	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lane
		logic [COMPONENT_WIDTH-1:0] mem [MAX_ROWS];
		logic [COMPONENT_WIDTH-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (wr_en && (32'(wr_dim) == g)) begin
				mem[wr_row] <= wr_data;
			end
			if (rd_en) begin
				rd_q <= mem[rd_row];
			end
		end

		assign rd_data[g] = rd_q;
	end

endmodule

`default_nettype wire

// ===== sv/nns_dist.sv =====
// Distance pipeline: per-lane squared differences, then saturated lane sum.
`default_nettype none

module nns_dist #(
	parameter int MAX_ROWS = nns_pkg::MAX_ROWS_DEF,
	parameter int MAX_DIMS = nns_pkg::MAX_DIMS_DEF,
	parameter int COMPONENT_WIDTH = nns_pkg::COMP_W_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire nns_pkg::tag_t                             tag_s1,
	input  wire logic [$clog2(MAX_ROWS)-1:0]               row_s1,
	input  wire logic [MAX_DIMS-1:0][COMPONENT_WIDTH-1:0]  feat_s1,
	input  wire logic [MAX_DIMS-1:0][COMPONENT_WIDTH-1:0]  query,
	input  wire logic [MAX_DIMS-1:0]                       lane_en,
	output nns_pkg::tag_t                                  tag_s3,
	output logic      [$clog2(MAX_ROWS)-1:0]               row_s3,
	output logic      [nns_pkg::DIST_W-1:0]                dist_s3
);
	import nns_pkg::*;

	localparam int CW    = COMPONENT_WIDTH;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int SQ_W  = 2 * CW;
	localparam int SUM_W = SQ_W + $clog2(MAX_DIMS + 1);
	localparam int CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

	logic [MAX_DIMS-1:0][SQ_W-1:0] sq;
	logic [MAX_DIMS-1:0][SQ_W-1:0] sq_s2;
	tag_t                          tag_s2;
	logic [ROW_W-1:0]              row_s2;
	logic [CMP_W-1:0]              sum;
	tag_t                          tag_q3;
	logic [ROW_W-1:0]              row_q3;
	logic [DIST_W-1:0]             dist_q3;

	// Stage 2: |feature - query| squared, zero for lanes past dims_in_use
	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_sq
		logic [CW:0]     diff;
		logic [CW-1:0]   mag;
		logic [SQ_W-1:0] mag_ext;

		assign diff    = {feat_s1[g][CW-1], feat_s1[g]} - {query[g][CW-1], query[g]};
		assign mag     = diff[CW] ? CW'(-diff) : diff[CW-1:0];
		assign mag_ext = SQ_W'(mag);
		assign sq[g]   = lane_en[g] ? (mag_ext * mag_ext) : '0;
	end

	always_ff @(posedge clk) begin
		sq_s2  <= sq;
		row_s2 <= row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	// Stage 3: sum over lanes, saturate to the output width
	always_comb begin
		sum = '0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			sum = sum + CMP_W'(sq_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		row_q3  <= row_s2;
		dist_q3 <= (sum > CMP_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q3 <= '0;
		end else begin
			tag_q3 <= tag_s2;
		end
	end

	assign tag_s3  = tag_q3;
	assign row_s3  = row_q3;
	assign dist_s3 = dist_q3;

endmodule

`default_nettype wire

// ===== sv/nns_best.sv =====
// Running minimum over scanned rows; lowest index wins a tie.
`default_nettype none

module nns_best #(
	parameter int MAX_ROWS = nns_pkg::MAX_ROWS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire nns_pkg::tag_t                tag_s3,
	input  wire logic [$clog2(MAX_ROWS)-1:0]  row_s3,
	input  wire logic [nns_pkg::DIST_W-1:0]   dist_s3,
	input  wire logic                         take,
	output logic                              done,
	output logic      [$clog2(MAX_ROWS)-1:0]  best_row,
	output logic      [nns_pkg::DIST_W-1:0]   best_dist
);
	import nns_pkg::*;

	localparam int ROW_W = $clog2(MAX_ROWS);

	logic [ROW_W-1:0]  best_row_q;
	logic [DIST_W-1:0] best_dist_q;
	logic              done_q;

	// First row seeds the minimum; later rows replace it only when strictly closer
	always_ff @(posedge clk) begin
		if (tag_s3.valid && (tag_s3.first || (dist_s3 < best_dist_q))) begin
			best_row_q  <= row_s3;
			best_dist_q <= dist_s3;
		end
	end

	// Result is ready once the last row has been compared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (tag_s3.valid && tag_s3.last) begin
			done_q <= 1'b1;
		end else if (take) begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign best_row  = best_row_q;
	assign best_dist = best_dist_q;

endmodule

`default_nettype wire

// ===== sv/nearest_neighbor_search.sv =====
// Brute-force nearest-neighbor search over a table of fixed-point feature rows.
// Request channel (req_valid / req_stall): a load item writes one component of
// one table row; a query item writes one component of the query vector. A
// query item with query_last set starts a scan of rows 0 .. rows_in_use-1.
// Response channel (rsp_valid / rsp_stall): one item per scan with the index
// of the closest row and its squared Euclidean distance (lowest index on a tie).
// Load items and query items without query_last are accepted while idle. A scan
// streams one table row per cycle from the component memories; req_stall stays
// high for the whole scan. Configuration is written through cfg_we / cfg_index /
// cfg_data; the user must do so only while idle; the block does not enforce it.
// A finished result sits in the output register while new items are accepted;
// if the receiver stalls and a second scan finishes, that result waits in the
// minimum tracker and req_stall stays high until the output register frees up.
// Reset clears the query vector to zero and sets rows_in_use = 1024 and
// dims_in_use = 5; table contents are undefined until loaded.
`default_nettype none

module nearest_neighbor_search #(
	parameter int MAX_ROWS = nns_pkg::MAX_ROWS_DEF,
	parameter int MAX_DIMS = nns_pkg::MAX_DIMS_DEF,
	parameter int COMPONENT_WIDTH = nns_pkg::COMP_W_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration
	input  wire logic                                 cfg_we,
	input  wire logic [nns_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [nns_pkg::CFG_DATA_W-1:0]       cfg_data,
	// Request channel
	input  wire logic                                 req_valid,
	output logic                                      req_stall,
	input  wire logic                                 req_type,
	input  wire logic [nns_pkg::ROW_IN_W-1:0]         row_index,
	input  wire logic [nns_pkg::DIM_IN_W-1:0]         dim_index,
	input  wire logic signed [COMPONENT_WIDTH-1:0]    component_value,
	input  wire logic                                 query_last,
	// Response channel
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_stall,
	output logic      [nns_pkg::ROW_IN_W-1:0]         nearest_row,
	output logic      [nns_pkg::DIST_W-1:0]           best_distance_sq
);
	import nns_pkg::*;

	localparam int CW     = COMPONENT_WIDTH;
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int RCL_W  = (RCNT_W > ROWS_CFG_W) ? RCNT_W : ROWS_CFG_W;
	localparam int DCNT_W = $clog2(MAX_DIMS + 1);
	localparam int DCL_W  = (DCNT_W > DIMS_CFG_W) ? DCNT_W : DIMS_CFG_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                        state_q;
	logic [ROWS_CFG_W-1:0]         rows_q;
	logic [DIMS_CFG_W-1:0]         dims_q;
	logic [MAX_DIMS-1:0][CW-1:0]   query_q;
	logic [ROW_W-1:0]              issue_row_q;
	tag_t                          tag_s1;
	logic [ROW_W-1:0]              row_s1;
	logic                          rsp_valid_q;
	logic [ROW_W-1:0]              rsp_row_q;
	logic [DIST_W-1:0]             rsp_dist_q;

	logic                          req_acc;
	logic                          load_wr;
	logic                          query_wr;
	logic                          scan_start;
	logic [RCL_W-1:0]              rows_cmp;
	logic [RCL_W-1:0]              rows_eff;
	logic [ROW_W-1:0]              last_row;
	logic [DCL_W-1:0]              dims_cmp;
	logic [DCL_W-1:0]              dims_eff;
	logic [MAX_DIMS-1:0]           lane_en;
	logic                          scanning;
	logic [MAX_DIMS-1:0][CW-1:0]   feat_s1;
	tag_t                          tag_s3;
	logic [ROW_W-1:0]              row_s3;
	logic [DIST_W-1:0]             dist_s3;
	logic                          best_done;
	logic [ROW_W-1:0]              best_row;
	logic [DIST_W-1:0]             best_dist;
	logic                          take;

	// Request decode
	assign req_stall  = (state_q != ST_IDLE);
	assign req_acc    = req_valid && !req_stall;
	assign load_wr    = req_acc && (req_type == REQ_LOAD) && (32'(row_index) < MAX_ROWS);
	assign query_wr   = req_acc && (req_type == REQ_QUERY);
	assign scan_start = query_wr && query_last;
	assign scanning   = (state_q == ST_SCAN);

	// Clamp the row and lane extents to the table size and lane count; zero counts as one
	always_comb begin
		rows_cmp = RCL_W'(rows_q);
		if (rows_cmp == '0) begin
			rows_eff = RCL_W'(1);
		end else if (rows_cmp > RCL_W'(MAX_ROWS)) begin
			rows_eff = RCL_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_cmp;
		end
		last_row = ROW_W'(rows_eff - RCL_W'(1));

		dims_cmp = DCL_W'(dims_q);
		if (dims_cmp == '0) begin
			dims_eff = DCL_W'(1);
		end else if (dims_cmp > DCL_W'(MAX_DIMS)) begin
			dims_eff = DCL_W'(MAX_DIMS);
		end else begin
			dims_eff = dims_cmp;
		end
	end

	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lane_en
		assign lane_en[g] = (DCL_W'(g) < dims_eff);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			dims_q <= DIMS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS: rows_q <= cfg_data[ROWS_CFG_W-1:0];
				REG_DIMS: dims_q <= cfg_data[DIMS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Query vector
	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_query
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				query_q[g] <= '0;
			end else if (query_wr && (32'(dim_index) == g)) begin
				query_q[g] <= component_value;
			end
		end
	end

	// Scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_row_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (scan_start) begin
						state_q     <= ST_SCAN;
						issue_row_q <= '0;
					end
				end
				ST_SCAN: begin
					if (issue_row_q == last_row) begin
						state_q <= ST_DRAIN;
					end else begin
						issue_row_q <= issue_row_q + ROW_W'(1);
					end
				end
				ST_DRAIN: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Tag rides alongside the memory read
	always_ff @(posedge clk) begin
		row_s1 <= issue_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= scanning;
			tag_s1.first <= (issue_row_q == '0);
			tag_s1.last  <= (issue_row_q == last_row);
		end
	end

	nns_table #(
		.MAX_ROWS        (MAX_ROWS),
		.MAX_DIMS        (MAX_DIMS),
		.COMPONENT_WIDTH (COMPONENT_WIDTH)
	) u_table (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_row  (ROW_W'(row_index)),
		.wr_dim  (dim_index),
		.wr_data (component_value),
		.rd_en   (scanning),
		.rd_row  (issue_row_q),
		.rd_data (feat_s1)
	);

	nns_dist #(
		.MAX_ROWS        (MAX_ROWS),
		.MAX_DIMS        (MAX_DIMS),
		.COMPONENT_WIDTH (COMPONENT_WIDTH)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.row_s1  (row_s1),
		.feat_s1 (feat_s1),
		.query   (query_q),
		.lane_en (lane_en),
		.tag_s3  (tag_s3),
		.row_s3  (row_s3),
		.dist_s3 (dist_s3)
	);

	nns_best #(
		.MAX_ROWS (MAX_ROWS)
	) u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s3    (tag_s3),
		.row_s3    (row_s3),
		.dist_s3   (dist_s3),
		.take      (take),
		.done      (best_done),
		.best_row  (best_row),
		.best_dist (best_dist)
	);

	// Output register
	assign take = best_done && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_row_q  <= best_row;
			rsp_dist_q <= best_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign nearest_row      = ROW_IN_W'(rsp_row_q);
	assign best_distance_sq = rsp_dist_q;

endmodule

`default_nettype wire
